// ===== hdl/rsac_pkg.sv =====
// ----------------------------------------------------------------------------
// Railway signal aspect controller package
// Shared codes, lamp assignment per aspect and the control bundle that the
// top level hands to each signal unit.
// ----------------------------------------------------------------------------
package rsac_pkg;

	localparam int unsigned LAMPS = 5;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned CMD_W = 16;
	localparam int unsigned ASPECT_W = 2;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [1:0] OP_COMMAND = 2'd0;
	localparam logic [1:0] OP_TICK    = 2'd1;
	localparam logic [1:0] OP_REFRESH = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_SIG1_ADDR  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SIG2_ADDR  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE_ADDR  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FULL_LEVEL = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DIM_LEVEL  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_DELAY      = 3'd5;

	localparam logic [ASPECT_W-1:0] ASPECT_HP00 = 2'd0;
	localparam logic [ASPECT_W-1:0] ASPECT_HP1  = 2'd1;
	localparam logic [ASPECT_W-1:0] ASPECT_HP2  = 2'd2;
	localparam logic [ASPECT_W-1:0] ASPECT_SH1  = 2'd3;

	localparam logic [CMD_W-1:0] NO_COMMAND = 16'hFFFF;
	localparam logic [LEVEL_W-1:0] FULL_LEVEL_RESET = 8'd255;
	localparam logic [LEVEL_W-1:0] DIM_LEVEL_RESET = 8'd64;
	localparam logic [LEVEL_W-1:0] DELAY_RESET = 8'd2;
	localparam logic [LEVEL_W-1:0] ELAPSED_MAX = 8'd255;

	typedef logic [LAMPS-1:0][LEVEL_W-1:0] lamp_set_t;

	typedef struct packed {
		logic step;
		logic request;
		logic [ASPECT_W-1:0] target;
		logic tick;
		logic refresh;
		logic [LEVEL_W-1:0] level;
		logic [LEVEL_W-1:0] delay;
	} sig_ctrl_t;

	// Lamp order: red_a, red_b, green, yellow, white (bit 0 upwards).
	function automatic logic [LAMPS-1:0] lamp_mask(input logic [ASPECT_W-1:0] aspect);
		logic [LAMPS-1:0] mask;
		case (aspect)
			ASPECT_HP00: mask = 5'b00011;
			ASPECT_HP1:  mask = 5'b00100;
			ASPECT_HP2:  mask = 5'b01100;
			ASPECT_SH1:  mask = 5'b10010;
			default:     mask = 5'b00000;
		endcase
		return mask;
	endfunction

endpackage

// ===== hdl/rsac_signal.sv =====
// ----------------------------------------------------------------------------
// Single signal unit
// Holds one signal's aspect, switch-over wait state and lamp levels, and works out
// their next values for one event.
// ----------------------------------------------------------------------------
module rsac_signal (
	input  logic                clk,
	input  logic                arst_n,
	input  rsac_pkg::sig_ctrl_t ctrl,
	output rsac_pkg::lamp_set_t lamps_next
);

	logic [rsac_pkg::ASPECT_W-1:0] aspect_q, aspect_n;
	logic                          pending_q, pending_n;
	logic [rsac_pkg::LEVEL_W-1:0]  elapsed_q, elapsed_n;
	rsac_pkg::lamp_set_t           lamps_q;
	logic [rsac_pkg::LAMPS-1:0]    mask_old, mask_new;

	assign mask_old = rsac_pkg::lamp_mask(aspect_q);
	assign mask_new = rsac_pkg::lamp_mask(aspect_n);

	always_comb begin
		aspect_n = aspect_q;
		pending_n = pending_q;
		elapsed_n = elapsed_q;
		lamps_next = lamps_q;
		if (ctrl.request && ctrl.target != aspect_q) begin
			if (!pending_q) begin
				for (int k = 0; k < rsac_pkg::LAMPS; k++) begin
					if (mask_old[k]) begin
						lamps_next[k] = '0;
					end
				end
			end
			aspect_n = ctrl.target;
			pending_n = 1'b1;
			elapsed_n = '0;
		end
		if (ctrl.tick && elapsed_q != rsac_pkg::ELAPSED_MAX) begin
			elapsed_n = elapsed_q + 8'd1;
		end
		if (ctrl.refresh && !pending_q) begin
			for (int k = 0; k < rsac_pkg::LAMPS; k++) begin
				if (mask_old[k]) begin
					lamps_next[k] = ctrl.level;
				end
			end
		end
		if (pending_n && elapsed_n >= ctrl.delay) begin
			for (int k = 0; k < rsac_pkg::LAMPS; k++) begin
				if (mask_new[k]) begin
					lamps_next[k] = ctrl.level;
				end
			end
			pending_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aspect_q <= rsac_pkg::ASPECT_HP00;
			pending_q <= 1'b1;
			elapsed_q <= rsac_pkg::ELAPSED_MAX;
			lamps_q <= '0;
		end else if (ctrl.step) begin
			aspect_q <= aspect_n;
			pending_q <= pending_n;
			elapsed_q <= elapsed_n;
			lamps_q <= lamps_next;
		end
	end

endmodule

// ===== hdl/railway_signal_aspect_controller.sv =====
// ----------------------------------------------------------------------------
// Railway signal aspect controller
// Decodes accessory commands, ticks and refresh events into lamp brightness
// targets for two four-aspect signals.
// ----------------------------------------------------------------------------
// Events arrive on the s_axis channel: tuser carries the operation (command,
// one-second tick or brightness refresh), tdata the command address. Every
// accepted transfer produces exactly one transfer on m_axis carrying the ten
// lamp targets after the event and a flag telling whether a new command hit
// a configured address.
// An event is captured in an input register and then handled once the result
// register can take it; the signal state and the result register update
// together, and one event can be taken every cycle while m_axis does not stall.
// When m_axis stalls, the result register holds; one further event may sit
// in the input register, after which s_axis_tready drops.
// Reset clears the registers to their defaults: both signals await HP00 with
// the delay already run out, so HP00 lights with the result of the first
// event. Configuration writes take effect on the next clock edge and are
// meant for idle periods only.
// ----------------------------------------------------------------------------
module railway_signal_aspect_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // command[15:0]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// s1_red_a, s1_red_b, s1_green, s1_yellow, s1_white, s2_red_a, s2_red_b,
	// s2_green, s2_yellow, s2_white (8 bits each), command_hit[80], zero fill
	output logic [87:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] sig1_addr_q, sig2_addr_q;
	logic [31:0] mode_addr_q;
	logic [7:0]  full_level_q, dim_level_q, delay_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] cmd_s1;

	logic        out_valid_s2;
	logic [87:0] out_data_s2;

	logic [15:0] last_cmd_q, last_cmd_n;
	logic        night_q, night_n;
	logic        hit;
	logic        step, out_ready;
	logic        req1, req2;
	logic [1:0]  target;
	logic [7:0]  level;

	rsac_pkg::sig_ctrl_t ctrl1, ctrl2;
	rsac_pkg::lamp_set_t lamps1, lamps2;

	assign out_ready = !out_valid_s2 || m_axis_tready;
	assign step = valid_s1 && out_ready;
	assign s_axis_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig1_addr_q <= '0;
			sig2_addr_q <= '0;
			mode_addr_q <= '0;
			full_level_q <= rsac_pkg::FULL_LEVEL_RESET;
			dim_level_q <= rsac_pkg::DIM_LEVEL_RESET;
			delay_q <= rsac_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rsac_pkg::REG_SIG1_ADDR:  sig1_addr_q <= cfg_data;
				rsac_pkg::REG_SIG2_ADDR:  sig2_addr_q <= cfg_data;
				rsac_pkg::REG_MODE_ADDR:  mode_addr_q <= cfg_data[31:0];
				rsac_pkg::REG_FULL_LEVEL: full_level_q <= cfg_data[7:0];
				rsac_pkg::REG_DIM_LEVEL:  dim_level_q <= cfg_data[7:0];
				rsac_pkg::REG_DELAY:      delay_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1 <= s_axis_tuser;
			cmd_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		last_cmd_n = last_cmd_q;
		night_n = night_q;
		hit = 1'b0;
		req1 = 1'b0;
		req2 = 1'b0;
		target = rsac_pkg::ASPECT_HP00;
		if (op_s1 == rsac_pkg::OP_COMMAND && cmd_s1 != last_cmd_q) begin
			last_cmd_n = cmd_s1;
			if (cmd_s1 == mode_addr_q[15:0]) begin
				night_n = 1'b0;
				hit = 1'b1;
			end else if (cmd_s1 == mode_addr_q[31:16]) begin
				night_n = 1'b1;
				hit = 1'b1;
			end else begin
				for (int i = 7; i >= 0; i--) begin
					if (cmd_s1 == (i < 4 ? sig1_addr_q[16*(i%4) +: 16]
							: sig2_addr_q[16*(i%4) +: 16])) begin
						hit = 1'b1;
						req1 = (i < 4);
						req2 = (i >= 4);
						target = 2'(i % 4);
					end
				end
			end
		end
	end

	assign level = night_n ? dim_level_q : full_level_q;

	always_comb begin
		ctrl1.step = step;
		ctrl1.request = req1;
		ctrl1.target = target;
		ctrl1.tick = (op_s1 == rsac_pkg::OP_TICK);
		ctrl1.refresh = (op_s1 == rsac_pkg::OP_REFRESH);
		ctrl1.level = level;
		ctrl1.delay = delay_q;
		ctrl2 = ctrl1;
		ctrl2.request = req2;
	end

	rsac_signal u_signal1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl1),
		.lamps_next (lamps1)
	);

	rsac_signal u_signal2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl2),
		.lamps_next (lamps2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cmd_q <= rsac_pkg::NO_COMMAND;
			night_q <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (step) begin
				last_cmd_q <= last_cmd_n;
				night_q <= night_n;
			end
			if (out_ready) begin
				out_valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_s2 <= {7'd0, hit, lamps2, lamps1};
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata = out_data_s2;

endmodule

// ===== tb/tb_railway_signal_aspect_controller.sv =====
// ----------------------------------------------------------------------------
// Testbench for the railway signal aspect controller
// Sends commands, ticks and refresh events over the input stream under
// several register settings. It predicts the ten lamp targets and the hit
// flag of every event with its own model of both signals, and compares each
// result transfer with the oldest prediction. Both stream sides idle at
// random, apart from one stretch in which neither side idles.
// ----------------------------------------------------------------------------
module tb_railway_signal_aspect_controller;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;
	localparam int QUIET_FROM = 400;
	localparam int QUIET_TO = 700;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] cmd;
	} signal_event_t;

	typedef struct packed {
		logic [9:0][7:0] lamp;
		logic            hit;
	} lamp_frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	railway_signal_aspect_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Register copies.
	logic [63:0] sig_addr [2] = '{64'd0, 64'd0};
	logic [31:0] mode_addr = '0;
	logic [7:0]  day_level = rsac_pkg::FULL_LEVEL_RESET;
	logic [7:0]  dark_level = rsac_pkg::DIM_LEVEL_RESET;
	logic [7:0]  switch_ticks = rsac_pkg::DELAY_RESET;

	// Signal state.
	logic [1:0]  sig_aspect [2] = '{rsac_pkg::ASPECT_HP00, rsac_pkg::ASPECT_HP00};
	logic        sig_waiting [2] = '{1'b1, 1'b1};
	logic [7:0]  sig_ticks [2] = '{rsac_pkg::ELAPSED_MAX, rsac_pkg::ELAPSED_MAX};
	logic [15:0] prior_cmd = rsac_pkg::NO_COMMAND;
	logic        night_on = 1'b0;
	logic [7:0]  lamp_now [10] = '{default: 8'd0};

	signal_event_t events_todo [$];
	lamp_frame_t   frames_due [$];
	logic [15:0]   addr_pool [10];
	logic [15:0]   last_sent_cmd = '0;
	string         lamp_names [10] = '{"s1_red_a", "s1_red_b", "s1_green", "s1_yellow",
		"s1_white", "s2_red_a", "s2_red_b", "s2_green", "s2_yellow", "s2_white"};

	int errors = 0;
	int events_taken = 0;
	int stall_cycles = 0;
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	bit quiet;

	assign quiet = events_taken >= QUIET_FROM && events_taken < QUIET_TO;

	function automatic logic [4:0] aspect_lamps(input logic [1:0] aspect);
		case (aspect)
			rsac_pkg::ASPECT_HP00: return 5'b00011;
			rsac_pkg::ASPECT_HP1:  return 5'b00100;
			rsac_pkg::ASPECT_HP2:  return 5'b01100;
			rsac_pkg::ASPECT_SH1:  return 5'b10010;
			default:               return 5'b00000;
		endcase
	endfunction

	function automatic logic [7:0] lit_level();
		return night_on ? dark_level : day_level;
	endfunction

	function automatic void set_lamps(input int sig, input logic [7:0] level);
		logic [4:0] mask;
		mask = aspect_lamps(sig_aspect[sig]);
		for (int k = 0; k < 5; k++)
			if (mask[k])
				lamp_now[sig * 5 + k] = level;
	endfunction

	// A lit signal goes dark first; one still waiting just takes the new aspect.
	function automatic void change_aspect(input int sig, input logic [1:0] target);
		if (sig_aspect[sig] != target) begin
			if (!sig_waiting[sig])
				set_lamps(sig, 8'd0);
			sig_aspect[sig] = target;
			sig_waiting[sig] = 1'b1;
			sig_ticks[sig] = 8'd0;
		end
	endfunction

	function automatic bit decode_command(input logic [15:0] cmd);
		if (cmd == prior_cmd)
			return 1'b0;
		prior_cmd = cmd;
		if (cmd == mode_addr[15:0]) begin
			night_on = 1'b0;
			return 1'b1;
		end
		if (cmd == mode_addr[31:16]) begin
			night_on = 1'b1;
			return 1'b1;
		end
		for (int i = 0; i < 8; i++) begin
			if (cmd == sig_addr[i / 4][16 * (i % 4) +: 16]) begin
				change_aspect(i / 4, 2'(i % 4));
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic lamp_frame_t predict_lamps(input signal_event_t ev);
		lamp_frame_t frame;
		frame.hit = 1'b0;
		case (ev.op)
			rsac_pkg::OP_COMMAND: frame.hit = decode_command(ev.cmd);
			rsac_pkg::OP_TICK: begin
				for (int s = 0; s < 2; s++)
					if (sig_ticks[s] != rsac_pkg::ELAPSED_MAX)
						sig_ticks[s]++;
			end
			rsac_pkg::OP_REFRESH: begin
				for (int s = 0; s < 2; s++)
					if (!sig_waiting[s])
						set_lamps(s, lit_level());
			end
			default: ;
		endcase
		for (int s = 0; s < 2; s++) begin
			if (sig_waiting[s] && sig_ticks[s] >= switch_ticks) begin
				set_lamps(s, lit_level());
				sig_waiting[s] = 1'b0;
			end
		end
		for (int k = 0; k < 10; k++)
			frame.lamp[k] = lamp_now[k];
		return frame;
	endfunction

	// Driver: a valid item is held until its transfer has taken place.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (events_todo.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= events_todo[0].cmd;
					s_axis_tuser <= events_todo[0].op;
					void'(events_todo.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= quiet || $urandom_range(99) >= 16;
		end
	end

	// Monitor: checks results, predicts accepted events and watches for a hang.
	always @(posedge clk) begin
		lamp_frame_t want;
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		out_taken = arst_n && m_axis_tvalid && m_axis_tready;
		if (out_taken) begin
			if (frames_due.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none, actual %h",
					$time, m_axis_tdata);
				errors++;
			end else begin
				want = frames_due.pop_front();
				for (int k = 0; k < 10; k++) begin
					if (m_axis_tdata[8 * k +: 8] !== want.lamp[k]) begin
						$display("%0t: %s expected %0d actual %0d", $time, lamp_names[k],
							want.lamp[k], m_axis_tdata[8 * k +: 8]);
						errors++;
					end
				end
				if (m_axis_tdata[80] !== want.hit) begin
					$display("%0t: command_hit expected %0d actual %0d", $time, want.hit,
						m_axis_tdata[80]);
					errors++;
				end
			end
		end
		if (in_taken) begin
			frames_due.push_back(predict_lamps('{op: s_axis_tuser, cmd: s_axis_tdata}));
			events_taken++;
		end
		if ((events_todo.size() != 0 || frames_due.size() != 0 || s_axis_tvalid)
				&& !in_taken && !out_taken)
			stall_cycles++;
		else
			stall_cycles = 0;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_event(input logic [1:0] op, input logic [15:0] cmd);
		events_todo.push_back('{op: op, cmd: cmd});
		if (op == rsac_pkg::OP_COMMAND)
			last_sent_cmd = cmd;
	endtask

	task automatic drain();
		while (events_todo.size() != 0 || frames_due.size() != 0 || s_axis_tvalid)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		case (index)
			rsac_pkg::REG_SIG1_ADDR:  sig_addr[0] = value;
			rsac_pkg::REG_SIG2_ADDR:  sig_addr[1] = value;
			rsac_pkg::REG_MODE_ADDR:  mode_addr = value[31:0];
			rsac_pkg::REG_FULL_LEVEL: day_level = value[7:0];
			rsac_pkg::REG_DIM_LEVEL:  dark_level = value[7:0];
			rsac_pkg::REG_DELAY:      switch_ticks = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [63:0] s1, input logic [63:0] s2,
			input logic [31:0] night, input logic [7:0] full, input logic [7:0] dim,
			input logic [7:0] delay);
		drain();
		write_reg(rsac_pkg::REG_SIG1_ADDR, s1);
		write_reg(rsac_pkg::REG_SIG2_ADDR, s2);
		write_reg(rsac_pkg::REG_MODE_ADDR, {32'd0, night});
		write_reg(rsac_pkg::REG_FULL_LEVEL, {56'd0, full});
		write_reg(rsac_pkg::REG_DIM_LEVEL, {56'd0, dim});
		write_reg(rsac_pkg::REG_DELAY, {56'd0, delay});
		for (int i = 0; i < 4; i++) begin
			addr_pool[i] = s1[16 * i +: 16];
			addr_pool[4 + i] = s2[16 * i +: 16];
		end
		addr_pool[8] = night[15:0];
		addr_pool[9] = night[31:16];
		@(posedge clk);
	endtask

	task automatic random_events(input int count);
		int pick;
		for (int j = 0; j < count; j++) begin
			pick = $urandom_range(99);
			if (pick < 50)
				queue_event(rsac_pkg::OP_COMMAND, addr_pool[$urandom_range(9)]);
			else if (pick < 58)
				queue_event(rsac_pkg::OP_COMMAND, 16'($urandom));
			else if (pick < 62)
				queue_event(rsac_pkg::OP_COMMAND, last_sent_cmd);
			else if (pick < 85)
				queue_event(rsac_pkg::OP_TICK, 16'($urandom));
			else if (pick < 96)
				queue_event(rsac_pkg::OP_REFRESH, 16'($urandom));
			else
				queue_event(OP_UNUSED, 16'($urandom));
		end
	endtask

	initial begin
		logic [63:0] s1;
		logic [63:0] s2;
		logic [31:0] night;
		logic [7:0]  full;
		logic [7:0]  dim;
		logic [7:0]  delay;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: every address is zero, so zero selects day mode.
		queue_event(rsac_pkg::OP_COMMAND, 16'h0000);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0000);
		queue_event(rsac_pkg::OP_TICK, 16'hFFFF);
		queue_event(rsac_pkg::OP_REFRESH, 16'h0000);
		queue_event(OP_UNUSED, 16'hFFFF);
		queue_event(rsac_pkg::OP_COMMAND, rsac_pkg::NO_COMMAND);
		queue_event(rsac_pkg::OP_COMMAND, 16'h1234);

		set_config(64'h0103_0102_0101_0100, 64'h0203_0202_0201_0200, 32'h0301_0300,
			8'd200, 8'd20, 8'd2);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0101);
		queue_event(rsac_pkg::OP_TICK, 16'h0000);
		queue_event(rsac_pkg::OP_TICK, 16'h0000);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0102);
		queue_event(rsac_pkg::OP_TICK, 16'h0000);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0103);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0103);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0200);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0203);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0301);
		queue_event(rsac_pkg::OP_REFRESH, 16'h0000);
		queue_event(rsac_pkg::OP_TICK, 16'h0000);
		queue_event(rsac_pkg::OP_TICK, 16'h0000);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0300);
		queue_event(OP_UNUSED, 16'h0000);
		queue_event(rsac_pkg::OP_REFRESH, 16'h0000);
		queue_event(rsac_pkg::OP_COMMAND, rsac_pkg::NO_COMMAND);
		queue_event(rsac_pkg::OP_COMMAND, 16'h0000);

		for (int p = 0; p < 8; p++) begin
			s1 = {$urandom, $urandom};
			s2 = {$urandom, $urandom};
			night = $urandom;
			full = (p == 0) ? 8'd255 : (p == 1) ? 8'd0 : 8'($urandom);
			dim = (p == 0) ? 8'd0 : (p == 2) ? 8'd255 : 8'($urandom);
			case (p)
				0: delay = 8'd0;
				1: delay = 8'd1;
				2: delay = 8'd2;
				3: delay = 8'd255;
				4: delay = 8'd3;
				default: delay = 8'($urandom_range(4));
			endcase
			// Overlapping addresses exercise the match priority.
			if (p == 5) begin
				s2 = s1;
				night[15:0] = s1[15:0];
				night[31:16] = s2[63:48];
			end
			if (p == 6) begin
				s1 = 64'h0000_FFFF_0000_FFFF;
				night = 32'hFFFF_0000;
			end
			set_config(s1, s2, night, full, dim, delay);
			random_events(75);
			if (delay > 8'd8) begin
				for (int t = 0; t < int'(delay) + 2; t++)
					queue_event(rsac_pkg::OP_TICK, 16'($urandom));
			end
			random_events(75);
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && frames_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
